[hdl/btpc_pkg.sv]
// Shared types, codes and the compensation microprogram.
`default_nettype none
package btpc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_9 = 2'd3;

  typedef struct packed {
    logic        func;
    logic [19:0] adc_raw;
  } btpc_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               div_zero;
  } btpc_out_t;

  localparam logic FUNC_TEMP = 1'b0;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_SHL   = 4'd4;
  localparam logic [3:0] OP_SHR   = 4'd5;
  localparam logic [3:0] OP_ASR   = 4'd6;
  localparam logic [3:0] OP_SX32  = 4'd7;
  localparam logic [3:0] OP_SETFT = 4'd8;
  localparam logic [3:0] OP_BZ    = 4'd9;
  localparam logic [3:0] OP_OUT   = 4'd10;
  localparam logic [3:0] OP_ZOUT  = 4'd11;

  localparam logic [1:0] R0 = 2'd0;
  localparam logic [1:0] R1 = 2'd1;
  localparam logic [1:0] R2 = 2'd2;
  localparam logic [1:0] R3 = 2'd3;

  localparam logic [4:0] S_R0      = 5'd0;
  localparam logic [4:0] S_R1      = 5'd1;
  localparam logic [4:0] S_R2      = 5'd2;
  localparam logic [4:0] S_R3      = 5'd3;
  localparam logic [4:0] S_FT      = 5'd4;
  localparam logic [4:0] S_ADC     = 5'd5;
  localparam logic [4:0] S_T1      = 5'd6;
  localparam logic [4:0] S_T2      = 5'd7;
  localparam logic [4:0] S_T3      = 5'd8;
  localparam logic [4:0] S_P1      = 5'd9;
  localparam logic [4:0] S_P2      = 5'd10;
  localparam logic [4:0] S_P3      = 5'd11;
  localparam logic [4:0] S_P4      = 5'd12;
  localparam logic [4:0] S_P5      = 5'd13;
  localparam logic [4:0] S_P6      = 5'd14;
  localparam logic [4:0] S_P7      = 5'd15;
  localparam logic [4:0] S_P8      = 5'd16;
  localparam logic [4:0] S_P9      = 5'd17;
  localparam logic [4:0] S_K128000 = 5'd18;
  localparam logic [4:0] S_K3125   = 5'd19;
  localparam logic [4:0] S_K2P47   = 5'd20;
  localparam logic [4:0] S_K1M     = 5'd21;
  localparam logic [4:0] S_K5      = 5'd22;
  localparam logic [4:0] S_K128    = 5'd23;
  localparam logic [4:0] S_ZERO    = 5'd24;

  localparam int PC_W = 6;
  localparam logic [PC_W-1:0] PC_TEMP  = 6'd0;
  localparam logic [PC_W-1:0] PC_PRESS = 6'd22;
  localparam logic [PC_W-1:0] PC_DZ    = 6'd56;

  typedef struct packed {
    logic [3:0]      op;
    logic [1:0]      dst;
    logic [4:0]      src_a;
    logic [4:0]      src_b;
    logic [5:0]      sh;
    logic [PC_W-1:0] tgt;
  } btpc_instr_t;

  typedef struct packed {
    logic        load_in;
    logic        start;
    btpc_instr_t ins;
  } btpc_cmd_t;

  typedef struct packed {
    logic done;
    logic r1_zero;
    logic out_full;
  } btpc_stat_t;

  function automatic btpc_instr_t mk(input logic [3:0] op, input logic [1:0] dst,
                                     input logic [4:0] a, input logic [4:0] b,
                                     input logic [5:0] sh);
    btpc_instr_t i;
    i.op    = op;
    i.dst   = dst;
    i.src_a = a;
    i.src_b = b;
    i.sh    = sh;
    i.tgt   = PC_DZ;
    return i;
  endfunction

  function automatic btpc_instr_t prog(input logic [PC_W-1:0] pc);
    btpc_instr_t i;
    unique case (pc)
      6'd0:  i = mk(OP_SHR,  R0, S_ADC,     S_ZERO,  6'd3);
      6'd1:  i = mk(OP_SHL,  R1, S_T1,      S_ZERO,  6'd1);
      6'd2:  i = mk(OP_SUB,  R0, S_R0,      S_R1,    6'd0);
      6'd3:  i = mk(OP_MUL,  R0, S_R0,      S_T2,    6'd0);
      6'd4:  i = mk(OP_SX32, R0, S_R0,      S_ZERO,  6'd0);
      6'd5:  i = mk(OP_ASR,  R0, S_R0,      S_ZERO,  6'd11);
      6'd6:  i = mk(OP_SHR,  R1, S_ADC,     S_ZERO,  6'd4);
      6'd7:  i = mk(OP_SUB,  R1, S_R1,      S_T1,    6'd0);
      6'd8:  i = mk(OP_MUL,  R1, S_R1,      S_R1,    6'd0);
      6'd9:  i = mk(OP_SX32, R1, S_R1,      S_ZERO,  6'd0);
      6'd10: i = mk(OP_ASR,  R1, S_R1,      S_ZERO,  6'd12);
      6'd11: i = mk(OP_MUL,  R1, S_R1,      S_T3,    6'd0);
      6'd12: i = mk(OP_SX32, R1, S_R1,      S_ZERO,  6'd0);
      6'd13: i = mk(OP_ASR,  R1, S_R1,      S_ZERO,  6'd14);
      6'd14: i = mk(OP_ADD,  R0, S_R0,      S_R1,    6'd0);
      6'd15: i = mk(OP_SX32, R0, S_R0,      S_ZERO,  6'd0);
      6'd16: i = mk(OP_SETFT, R0, S_R0,     S_ZERO,  6'd0);
      6'd17: i = mk(OP_MUL,  R0, S_R0,      S_K5,    6'd0);
      6'd18: i = mk(OP_ADD,  R0, S_R0,      S_K128,  6'd0);
      6'd19: i = mk(OP_SX32, R0, S_R0,      S_ZERO,  6'd0);
      6'd20: i = mk(OP_ASR,  R0, S_R0,      S_ZERO,  6'd8);
      6'd21: i = mk(OP_OUT,  R0, S_R0,      S_ZERO,  6'd0);
      6'd22: i = mk(OP_SUB,  R0, S_FT,      S_K128000, 6'd0);
      6'd23: i = mk(OP_MUL,  R1, S_R0,      S_R0,    6'd0);
      6'd24: i = mk(OP_MUL,  R2, S_R1,      S_P6,    6'd0);
      6'd25: i = mk(OP_MUL,  R3, S_R0,      S_P5,    6'd0);
      6'd26: i = mk(OP_SHL,  R3, S_R3,      S_ZERO,  6'd17);
      6'd27: i = mk(OP_ADD,  R2, S_R2,      S_R3,    6'd0);
      6'd28: i = mk(OP_SHL,  R3, S_P4,      S_ZERO,  6'd35);
      6'd29: i = mk(OP_ADD,  R2, S_R2,      S_R3,    6'd0);
      6'd30: i = mk(OP_MUL,  R3, S_R1,      S_P3,    6'd0);
      6'd31: i = mk(OP_ASR,  R3, S_R3,      S_ZERO,  6'd8);
      6'd32: i = mk(OP_MUL,  R1, S_R0,      S_P2,    6'd0);
      6'd33: i = mk(OP_SHL,  R1, S_R1,      S_ZERO,  6'd12);
      6'd34: i = mk(OP_ADD,  R1, S_R3,      S_R1,    6'd0);
      6'd35: i = mk(OP_ADD,  R1, S_R1,      S_K2P47, 6'd0);
      6'd36: i = mk(OP_MUL,  R1, S_R1,      S_P1,    6'd0);
      6'd37: i = mk(OP_ASR,  R1, S_R1,      S_ZERO,  6'd33);
      6'd38: i = mk(OP_BZ,   R1, S_R1,      S_ZERO,  6'd0);
      6'd39: i = mk(OP_SUB,  R0, S_K1M,     S_ADC,   6'd0);
      6'd40: i = mk(OP_SHL,  R0, S_R0,      S_ZERO,  6'd31);
      6'd41: i = mk(OP_SUB,  R0, S_R0,      S_R2,    6'd0);
      6'd42: i = mk(OP_MUL,  R0, S_R0,      S_K3125, 6'd0);
      6'd43: i = mk(OP_DIV,  R0, S_R0,      S_R1,    6'd0);
      6'd44: i = mk(OP_ASR,  R2, S_R0,      S_ZERO,  6'd13);
      6'd45: i = mk(OP_MUL,  R3, S_P9,      S_R2,    6'd0);
      6'd46: i = mk(OP_MUL,  R3, S_R3,      S_R2,    6'd0);
      6'd47: i = mk(OP_ASR,  R3, S_R3,      S_ZERO,  6'd25);
      6'd48: i = mk(OP_MUL,  R2, S_P8,      S_R0,    6'd0);
      6'd49: i = mk(OP_ASR,  R2, S_R2,      S_ZERO,  6'd19);
      6'd50: i = mk(OP_ADD,  R0, S_R0,      S_R3,    6'd0);
      6'd51: i = mk(OP_ADD,  R0, S_R0,      S_R2,    6'd0);
      6'd52: i = mk(OP_ASR,  R0, S_R0,      S_ZERO,  6'd8);
      6'd53: i = mk(OP_SHL,  R1, S_P7,      S_ZERO,  6'd4);
      6'd54: i = mk(OP_ADD,  R0, S_R0,      S_R1,    6'd0);
      6'd55: i = mk(OP_OUT,  R0, S_R0,      S_ZERO,  6'd0);
      default: i = mk(OP_ZOUT, R0, S_ZERO,  S_ZERO,  6'd0);
    endcase
    return i;
  endfunction

endpackage
`default_nettype wire

[hdl/btpc_ctrl.sv]
// Sequencer that steps through the compensation microprogram.
`default_nettype none
module btpc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_func,
  input  btpc_pkg::btpc_stat_t      stat,
  output btpc_pkg::btpc_cmd_t       cmd
);
  import btpc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]      state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  btpc_instr_t     ins;

  assign ins      = prog(pc);
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next  = state;
    pc_next     = pc;
    cmd.load_in = 1'b0;
    cmd.start   = 1'b0;
    cmd.ins     = ins;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          pc_next     = (in_func == FUNC_TEMP) ? PC_TEMP : PC_PRESS;
          state_next  = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (ins.op == OP_BZ) begin
          pc_next = stat.r1_zero ? ins.tgt : pc + 1'b1;
        end else if (ins.op == OP_OUT || ins.op == OP_ZOUT) begin
          if (!stat.out_full) begin
            cmd.start  = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.start  = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.done) begin
          pc_next    = pc + 1'b1;
          state_next = ST_ISSUE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= PC_TEMP;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> (state == ST_ISSUE))
    else $error("accepted beat did not start the program");

  a_out_only_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.start && (ins.op == OP_OUT || ins.op == OP_ZOUT)) |-> !stat.out_full)
    else $error("result issued while output register full");

endmodule
`default_nettype wire

[hdl/btpc_dp.sv]
// Datapath: coefficients, work registers, serial multiply/divide unit, result register.
`default_nettype none
module btpc_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  btpc_pkg::btpc_cmd_t                     cmd,
  output btpc_pkg::btpc_stat_t                    stat,
  input  btpc_pkg::btpc_in_t                      in_data,
  input  wire logic                               cfg_we,
  input  wire logic [btpc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [btpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output btpc_pkg::btpc_out_t                     out_data
);
  import btpc_pkg::*;

  logic [47:0] temp_coeffs;
  logic [63:0] press_a, press_b;
  logic [15:0] press_nine;
  logic [31:0] fine_temp;
  logic [19:0] adc;
  logic [63:0] r0, r1, r2, r3;
  logic [63:0] acc, mc, mp;
  logic [5:0]  cnt;
  logic        busy, fin, is_div, neg, done;
  logic [1:0]  dst_q;
  logic signed [31:0] res_value;
  logic        res_dz;

  logic [63:0] opa, opb, alu;
  logic        wr_en;
  logic [1:0]  wr_dst;
  logic [63:0] wr_val;
  logic [64:0] trial;
  logic [31:0] sat_val;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] pick(input logic [4:0] code);
    logic [63:0] v;
    case (code)
      S_R0:      v = r0;
      S_R1:      v = r1;
      S_R2:      v = r2;
      S_R3:      v = r3;
      S_FT:      v = {{32{fine_temp[31]}}, fine_temp};
      S_ADC:     v = {44'd0, adc};
      S_T1:      v = {48'd0, temp_coeffs[15:0]};
      S_T2:      v = sx16(temp_coeffs[31:16]);
      S_T3:      v = sx16(temp_coeffs[47:32]);
      S_P1:      v = {48'd0, press_a[15:0]};
      S_P2:      v = sx16(press_a[31:16]);
      S_P3:      v = sx16(press_a[47:32]);
      S_P4:      v = sx16(press_a[63:48]);
      S_P5:      v = sx16(press_b[15:0]);
      S_P6:      v = sx16(press_b[31:16]);
      S_P7:      v = sx16(press_b[47:32]);
      S_P8:      v = sx16(press_b[63:48]);
      S_P9:      v = sx16(press_nine);
      S_K128000: v = 64'd128000;
      S_K3125:   v = 64'd3125;
      S_K2P47:   v = 64'd1 << 47;
      S_K1M:     v = 64'd1048576;
      S_K5:      v = 64'd5;
      S_K128:    v = 64'd128;
      default:   v = 64'd0;
    endcase
    return v;
  endfunction

  assign opa = pick(cmd.ins.src_a);
  assign opb = pick(cmd.ins.src_b);

  always_comb begin
    case (cmd.ins.op)
      OP_ADD:  alu = opa + opb;
      OP_SUB:  alu = opa - opb;
      OP_SHL:  alu = opa << cmd.ins.sh;
      OP_SHR:  alu = opa >> cmd.ins.sh;
      OP_ASR:  alu = 64'($signed(opa) >>> cmd.ins.sh);
      OP_SX32: alu = {{32{opa[31]}}, opa[31:0]};
      default: alu = opa;
    endcase
  end

  always_comb begin
    if (opa[63:31] == {33{opa[63]}}) begin
      sat_val = opa[31:0];
    end else if (opa[63]) begin
      sat_val = 32'h8000_0000;
    end else begin
      sat_val = 32'h7FFF_FFFF;
    end
  end

  assign trial = {acc, mp[63]} - {1'b0, mc};

  always_comb begin
    wr_en  = 1'b0;
    wr_dst = dst_q;
    wr_val = acc;
    if (fin) begin
      wr_en  = 1'b1;
      wr_val = is_div ? (neg ? 64'd0 - mp : mp) : acc;
    end else if (cmd.start) begin
      case (cmd.ins.op)
        OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_ASR, OP_SX32: begin
          wr_en  = 1'b1;
          wr_dst = cmd.ins.dst;
          wr_val = alu;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (wr_dst)
        R0: r0 <= wr_val;
        R1: r1 <= wr_val;
        R2: r2 <= wr_val;
        R3: r3 <= wr_val;
        default: r0 <= wr_val;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      adc <= in_data.adc_raw;
    end
    if (cmd.start && (cmd.ins.op == OP_MUL || cmd.ins.op == OP_DIV)) begin
      dst_q  <= cmd.ins.dst;
      is_div <= (cmd.ins.op == OP_DIV);
      acc    <= 64'd0;
      cnt    <= 6'd0;
      if (cmd.ins.op == OP_DIV) begin
        neg <= opa[63] ^ opb[63];
        mp  <= opa[63] ? 64'd0 - opa : opa;
        mc  <= opb[63] ? 64'd0 - opb : opb;
      end else begin
        neg <= 1'b0;
        mp  <= opb;
        mc  <= opa;
      end
    end else if (busy && !fin) begin
      cnt <= cnt + 1'b1;
      if (is_div) begin
        if (!trial[64]) begin
          acc <= trial[63:0];
          mp  <= {mp[62:0], 1'b1};
        end else begin
          acc <= {acc[62:0], mp[63]};
          mp  <= {mp[62:0], 1'b0};
        end
      end else begin
        if (mp[0]) begin
          acc <= acc + mc;
        end
        mc <= mc << 1;
        mp <= mp >> 1;
      end
    end
    if (cmd.start && cmd.ins.op == OP_OUT) begin
      res_value <= sat_val;
      res_dz    <= 1'b0;
    end else if (cmd.start && cmd.ins.op == OP_ZOUT) begin
      res_value <= '0;
      res_dz    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      fin         <= 1'b0;
      done        <= 1'b0;
      out_valid   <= 1'b0;
      fine_temp   <= '0;
      temp_coeffs <= '0;
      press_a     <= '0;
      press_b     <= '0;
      press_nine  <= '0;
    end else begin
      done <= fin || (cmd.start && cmd.ins.op != OP_MUL && cmd.ins.op != OP_DIV &&
                      cmd.ins.op != OP_OUT && cmd.ins.op != OP_ZOUT);
      if (cmd.start) begin
        case (cmd.ins.op)
          OP_MUL, OP_DIV: busy <= 1'b1;
          OP_SETFT: fine_temp <= opa[31:0];
          OP_OUT, OP_ZOUT: out_valid <= 1'b1;
          default: busy <= 1'b0;
        endcase
      end else if (fin) begin
        fin  <= 1'b0;
        busy <= 1'b0;
      end else if (busy && cnt == 6'd63) begin
        fin <= 1'b1;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TEMP:    temp_coeffs <= cfg_data[47:0];
          CFG_PRESS_A: press_a     <= cfg_data;
          CFG_PRESS_B: press_b     <= cfg_data;
          CFG_PRESS_9: press_nine  <= cfg_data[15:0];
          default:     press_nine  <= press_nine;
        endcase
      end
    end
  end

  assign stat.done     = done;
  assign stat.r1_zero  = (r1 == 64'd0);
  assign stat.out_full = out_valid;
  assign out_data.value    = res_value;
  assign out_data.div_zero = res_dz;

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !busy)
    else $error("command issued while multiply/divide unit busy");

  a_fin_ends: assert property (@(posedge clk) disable iff (rst)
    fin |=> (!busy && done))
    else $error("serial unit did not finish cleanly");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(res_value) && $stable(res_dz))
    else $error("result register changed while beat stalled");

endmodule
`default_nettype wire

[hdl/baro_temp_pressure_compensation.sv]
// Top level of the barometric temperature and pressure compensation block.
// One beat in, one beat out. A temperature beat (func 0) updates the stored fine
// temperature, which a pressure beat (func 1) then uses. The duration of a beat is
// set mostly by the single bit-serial multiply/divide unit, which performs every 64-bit
// multiplication and division (4 for temperature, 11 for pressure). The block takes
// one beat at a time; a finished result waits in the output register while the
// next beat is taken. The user must write coefficient registers only while the
// block is idle; the block itself does not enforce this.
`default_nettype none
module baro_temp_pressure_compensation (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  btpc_pkg::btpc_in_t                      in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output btpc_pkg::btpc_out_t                     out_data,
  input  wire logic                               cfg_we,
  input  wire logic [btpc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [btpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import btpc_pkg::*;

  btpc_cmd_t  cmd;
  btpc_stat_t stat;

  btpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_func  (in_data.func),
    .stat     (stat),
    .cmd      (cmd)
  );

  btpc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
